// ===== rtl/met_pkg.sv =====
package met_pkg;

   // number format and field widths
   localparam int FRAC_BITS = 28;
   localparam int MAX_DIM   = 4096;
   localparam int WORD_W    = FRAC_BITS + 4;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int SUM_W     = PROD_W - FRAC_BITS + 4;
   localparam int PIX_W     = $clog2(MAX_DIM);
   localparam int WIDTH_W   = 13;
   localparam int LIMIT_W   = 16;
   localparam int COUNT_W   = 16;
   localparam int SHADE_W   = 8;
   localparam int ADDR_W    = 26;
   localparam int CSR_W     = 16;

   // coordinate divider: numerator below 2^17, shifted up by up to FRAC_BITS-1
   localparam int NUM_W     = 17;
   localparam int DIV_LEN   = NUM_W + FRAC_BITS - 1;
   localparam int DIV_CNT_W = $clog2(DIV_LEN + 1);

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic signed [WORD_W-1:0] RE_OFFSET = WORD_W'(2) << FRAC_BITS;
   localparam logic signed [WORD_W-1:0] IM_OFFSET = WORD_W'(5) << (FRAC_BITS - 2);
   // escape radius squared, 4.0 at the scale of a full product
   localparam logic [PROD_W:0] ESC_LIMIT = (PROD_W+1)'(1) << (2 * FRAC_BITS + 2);

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH     = 1'b0,
      CSR_ITERATION_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MAG,
      B_MUL_RR,
      B_MUL_II,
      B_MUL_RI,
      B_UPDATE,
      B_FINISH
   } back_state_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] image_width;
      logic [LIMIT_W-1:0] iteration_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] c_re;
      logic signed [WORD_W-1:0] c_im;
      logic [ADDR_W-1:0]        byte_address;
   } point_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  byte_address;
      logic [SHADE_W-1:0] shade;
      logic               in_set;
      logic [COUNT_W-1:0] iteration_count;
   } result_type;

endpackage

// ===== rtl/met_div.sv =====
module met_div (
   input  logic                            clock,
   input  logic                            load,
   input  logic                            step,
   input  logic [met_pkg::DIV_LEN-1:0]     dividend,
   input  logic [met_pkg::WIDTH_W-1:0]     divisor,
   output logic [met_pkg::WORD_W-1:0]      quotient
);

   logic [met_pkg::DIV_LEN-1:0] dvd_ff, dvd_in;
   logic [met_pkg::WIDTH_W-1:0] rem_ff, rem_in;
   logic [met_pkg::WORD_W-1:0]  q_ff, q_in;

   logic [met_pkg::WIDTH_W:0]   rem_wide;
   logic [met_pkg::WIDTH_W:0]   rem_sub;
   logic                        ge;
   logic [met_pkg::WORD_W-1:0]  q_wide;

   // restoring division, one quotient bit a step, quotient clamped at the word maximum
   always_comb begin
      rem_wide = {rem_ff, dvd_ff[met_pkg::DIV_LEN-1]};
      rem_sub  = rem_wide - {1'b0, divisor};
      ge       = rem_wide >= {1'b0, divisor};
      q_wide   = {q_ff[met_pkg::WORD_W-2:0], ge};
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      if (load) begin
         dvd_in = dividend;
         rem_in = '0;
         q_in   = '0;
      end else if (step) begin
         dvd_in = dvd_ff << 1;
         rem_in = ge ? rem_sub[met_pkg::WIDTH_W-1:0] : rem_wide[met_pkg::WIDTH_W-1:0];
         q_in   = q_wide[met_pkg::WORD_W-1] ? met_pkg::WORD_MAX : q_wide;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign quotient = q_ff;

endmodule

// ===== rtl/met_front.sv =====
module met_front (
   input  logic                          clock,
   input  logic                          reset,
   input  met_pkg::cfg_type              cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [met_pkg::PIX_W-1:0]     pixel_x,
   input  logic [met_pkg::PIX_W-1:0]     pixel_y,
   output logic                          push,
   output met_pkg::point_type            point,
   input  logic                          full
);

   met_pkg::front_state_type state_ff, state_in;
   logic [met_pkg::DIV_CNT_W-1:0]          step_ff, step_in;
   logic [met_pkg::PIX_W-1:0]              px_ff, px_in, py_ff, py_in;
   logic [met_pkg::WIDTH_W+met_pkg::PIX_W-1:0] prod_ff, prod_in;

   logic                          load, step;
   logic [met_pkg::NUM_W-1:0]     num_re, num_im;
   logic [met_pkg::DIV_LEN-1:0]   dividend_re, dividend_im;
   logic [met_pkg::WIDTH_W-1:0]   divisor;
   logic [met_pkg::WORD_W-1:0]    quot_re, quot_im;
   logic [met_pkg::ADDR_W-1:0]    addr_base;

   // 3.25 = 13/4 and 2.5 = 5/2, folded into the numerator and the shift
   always_comb begin
      num_re      = met_pkg::NUM_W'(13 * pixel_x);
      num_im      = met_pkg::NUM_W'(5 * pixel_y);
      dividend_re = met_pkg::DIV_LEN'({num_re, (met_pkg::FRAC_BITS-2)'(0)});
      dividend_im = {num_im, (met_pkg::FRAC_BITS-1)'(0)};
      divisor     = (cfg.image_width == '0) ? met_pkg::WIDTH_W'(1) : cfg.image_width;
   end

   met_div u_div_re (
      .clock    (clock),
      .load     (load),
      .step     (step),
      .dividend (dividend_re),
      .divisor  (divisor),
      .quotient (quot_re)
   );

   met_div u_div_im (
      .clock    (clock),
      .load     (load),
      .step     (step),
      .dividend (dividend_im),
      .divisor  (divisor),
      .quotient (quot_im)
   );

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      prod_in  = prod_ff;
      in_ready = 1'b0;
      load     = 1'b0;
      step     = 1'b0;
      push     = 1'b0;
      unique case (state_ff)
         met_pkg::F_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               load     = 1'b1;
               px_in    = pixel_x;
               py_in    = pixel_y;
               step_in  = '0;
               state_in = met_pkg::F_DIV;
            end
         end
         met_pkg::F_DIV: begin
            step    = 1'b1;
            step_in = step_ff + 1'b1;
            prod_in = cfg.image_width * py_ff;
            if (step_ff == met_pkg::DIV_CNT_W'(met_pkg::DIV_LEN - 1)) begin
               state_in = met_pkg::F_PUSH;
            end
         end
         met_pkg::F_PUSH: begin
            if (!full) begin
               push     = 1'b1;
               state_in = met_pkg::F_IDLE;
            end
         end
         default: state_in = met_pkg::F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= met_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      prod_ff <= prod_in;
   end

   // 3*(width*y + x), wrapping at the address width
   always_comb begin
      addr_base          = met_pkg::ADDR_W'(prod_ff) + met_pkg::ADDR_W'(px_ff);
      point.byte_address = (addr_base << 1) + addr_base;
      point.c_re         = $signed(quot_re) - met_pkg::RE_OFFSET;
      point.c_im         = $signed(quot_im) - met_pkg::IM_OFFSET;
   end

endmodule

// ===== rtl/met_fifo.sv =====
module met_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  met_pkg::point_type wdata,
   output logic               full,
   input  logic               pop,
   output met_pkg::point_type rdata,
   output logic               empty
);

   met_pkg::point_type               mem_ff [met_pkg::FIFO_DEPTH];
   logic [met_pkg::FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [met_pkg::FIFO_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == met_pkg::FIFO_PTR_W'(met_pkg::FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == met_pkg::FIFO_PTR_W'(met_pkg::FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign full  = (count_ff == met_pkg::FIFO_CNT_W'(met_pkg::FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

endmodule

// ===== rtl/met_back.sv =====
module met_back (
   input  logic               clock,
   input  logic               reset,
   input  met_pkg::cfg_type   cfg,
   input  logic               empty,
   output logic               pop,
   input  met_pkg::point_type point,
   output logic               out_valid,
   input  logic               out_ready,
   output met_pkg::result_type result
);

   met_pkg::back_state_type state_ff, state_in;

   logic signed [met_pkg::WORD_W-1:0] c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic [met_pkg::ADDR_W-1:0]        addr_ff, addr_in;
   logic signed [met_pkg::WORD_W-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic [met_pkg::WORD_W-1:0]        mr_ff, mr_in, mi_ff, mi_in;
   logic                              neg_ff, neg_in;
   logic [met_pkg::PROD_W-1:0]        rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic                              esc_ff, esc_in;
   logic [met_pkg::COUNT_W-1:0]       count_ff, count_in;
   met_pkg::result_type               res_ff, res_in;
   logic                              out_valid_ff, out_valid_in;

   logic [met_pkg::WORD_W-1:0]        mul_a, mul_b;
   logic [met_pkg::PROD_W-1:0]        product;
   logic [met_pkg::PROD_W-met_pkg::FRAC_BITS:0] cross_mag;
   logic                              cross_low;
   logic signed [met_pkg::SUM_W-1:0]  cross_term, zi_sum, zr_sum;
   logic                              in_set, res_load;

   function automatic logic signed [met_pkg::WORD_W-1:0] sat_word(
      input logic signed [met_pkg::SUM_W-1:0] v
   );
      logic [met_pkg::SUM_W-met_pkg::WORD_W:0] top;
      top = v[met_pkg::SUM_W-1:met_pkg::WORD_W-1];
      if (top == '0 || top == '1) begin
         return v[met_pkg::WORD_W-1:0];
      end else if (v[met_pkg::SUM_W-1]) begin
         return met_pkg::WORD_MIN;
      end else begin
         return met_pkg::WORD_MAX;
      end
   endfunction

   // one shared multiplier, three products per iteration
   always_comb begin
      unique case (state_ff)
         met_pkg::B_MUL_RR: begin
            mul_a = mr_ff;
            mul_b = mr_ff;
         end
         met_pkg::B_MUL_II: begin
            mul_a = mi_ff;
            mul_b = mi_ff;
         end
         default: begin
            mul_a = mr_ff;
            mul_b = mi_ff;
         end
      endcase
      product = mul_a * mul_b;
   end

   // new z: squares and the doubled cross term floored to the word scale
   always_comb begin
      cross_mag  = ri_ff[met_pkg::PROD_W-1:met_pkg::FRAC_BITS-1];
      cross_low  = |ri_ff[met_pkg::FRAC_BITS-2:0];
      cross_term = neg_ff ? -(met_pkg::SUM_W'(cross_mag) + met_pkg::SUM_W'(cross_low))
                          : met_pkg::SUM_W'(cross_mag);
      zi_sum     = cross_term + met_pkg::SUM_W'(c_im_ff);
      zr_sum     = met_pkg::SUM_W'(rr_ff[met_pkg::PROD_W-1:met_pkg::FRAC_BITS])
                 - met_pkg::SUM_W'(ii_ff[met_pkg::PROD_W-1:met_pkg::FRAC_BITS])
                 + met_pkg::SUM_W'(c_re_ff);
      in_set     = (count_ff == cfg.iteration_limit);
   end

   always_comb begin
      state_in     = state_ff;
      c_re_in      = c_re_ff;
      c_im_in      = c_im_ff;
      addr_in      = addr_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      mr_in        = mr_ff;
      mi_in        = mi_ff;
      neg_in       = neg_ff;
      rr_in        = rr_ff;
      ii_in        = ii_ff;
      ri_in        = ri_ff;
      esc_in       = esc_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !out_ready;
      pop          = 1'b0;
      res_load     = 1'b0;
      unique case (state_ff)
         met_pkg::B_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               c_re_in  = point.c_re;
               c_im_in  = point.c_im;
               addr_in  = point.byte_address;
               zr_in    = '0;
               zi_in    = '0;
               count_in = '0;
               state_in = (cfg.iteration_limit == '0) ? met_pkg::B_FINISH : met_pkg::B_MAG;
            end
         end
         met_pkg::B_MAG: begin
            mr_in    = zr_ff[met_pkg::WORD_W-1] ? met_pkg::WORD_W'(-zr_ff) : zr_ff;
            mi_in    = zi_ff[met_pkg::WORD_W-1] ? met_pkg::WORD_W'(-zi_ff) : zi_ff;
            neg_in   = zr_ff[met_pkg::WORD_W-1] ^ zi_ff[met_pkg::WORD_W-1];
            state_in = met_pkg::B_MUL_RR;
         end
         met_pkg::B_MUL_RR: begin
            rr_in    = product;
            state_in = met_pkg::B_MUL_II;
         end
         met_pkg::B_MUL_II: begin
            ii_in    = product;
            state_in = met_pkg::B_MUL_RI;
         end
         met_pkg::B_MUL_RI: begin
            ri_in    = product;
            esc_in   = ({1'b0, rr_ff} + {1'b0, ii_ff}) > met_pkg::ESC_LIMIT;
            state_in = met_pkg::B_UPDATE;
         end
         met_pkg::B_UPDATE: begin
            if (esc_ff) begin
               state_in = met_pkg::B_FINISH;
            end else begin
               zr_in    = sat_word(zr_sum);
               zi_in    = sat_word(zi_sum);
               count_in = count_ff + 1'b1;
               state_in = (count_ff + 1'b1 == cfg.iteration_limit) ?
                          met_pkg::B_FINISH : met_pkg::B_MAG;
            end
         end
         met_pkg::B_FINISH: begin
            if (!out_valid_ff || out_ready) begin
               res_load               = 1'b1;
               res_in.iteration_count = count_ff;
               res_in.in_set          = in_set;
               res_in.shade           = in_set ? '0 : count_ff[met_pkg::SHADE_W-1:0];
               res_in.byte_address    = addr_ff;
               out_valid_in           = 1'b1;
               state_in               = met_pkg::B_IDLE;
            end
         end
         default: state_in = met_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= met_pkg::B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      c_re_ff  <= c_re_in;
      c_im_ff  <= c_im_in;
      addr_ff  <= addr_in;
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      mr_ff    <= mr_in;
      mi_ff    <= mi_in;
      neg_ff   <= neg_in;
      rr_ff    <= rr_in;
      ii_ff    <= ii_in;
      ri_ff    <= ri_in;
      esc_ff   <= esc_in;
      count_ff <= count_in;
      res_ff   <= res_in;
   end

   assign out_valid = out_valid_ff;
   assign result    = res_ff;

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (!out_valid_ff || out_ready))
      else $error("result register overwritten while still held");

   a_shade_in_set: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && res_ff.in_set) |-> (res_ff.shade == '0))
      else $error("shade not cleared for a point in the set");

   a_product_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == met_pkg::B_MUL_RI) |-> ($past(state_ff) == met_pkg::B_MUL_II))
      else $error("cross product taken without both squares");

endmodule

// ===== rtl/mandelbrot_escape_time_pixel.sv =====
// escape-time pixel engine for the mandelbrot set. each req word is one pixel
// (column, row); it maps to c = x/width*3.25 - 2 + i*(y/width*2.5 - 1.25) in signed
// q4.28 and z = z^2 + c is iterated from zero until |z|^2 exceeds 4 or the count
// reaches iteration_limit. one rsp word per pixel carries the count, the in-set flag,
// the grey shade (count mod 256, 0 inside the set) and the byte offset 3*width*y + 3*x.
// a front end works out c with two bit-serial dividers and hands it through a two-word
// queue to the iteration engine, which runs each iteration on its single shared 32x32
// multiplier (magnitudes, three products, update). a pixel that reaches the limit
// finishes after its last update; one that escapes also spends a full iteration on the
// pass that detects it. the engine takes one pixel at a time, and that loop sets the
// throughput; the reset limit is 5000. a finished result waits in an output register
// while the engine starts the next pixel. csr writes are meant for idle periods only.
module mandelbrot_escape_time_pixel (
   input  logic                          clock,
   input  logic                          reset,
   // pixel input
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,   // pixel_x[11:0], pixel_y[23:12]
   // result output
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [55:0]                   rsp_tdata,   // iteration_count[15:0], in_set[16],
                                                      // shade[24:17], byte_address[50:25],
                                                      // zero fill[55:51]
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [0:0]                    csr_index,
   input  logic [met_pkg::CSR_W-1:0]     csr_data
);

   // configuration registers
   logic [met_pkg::WIDTH_W-1:0] width_ff, width_in;
   logic [met_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   met_pkg::cfg_type            cfg;

   met_pkg::point_type          fe_point, be_point;
   logic                        fe_push, q_full, be_pop, q_empty;
   met_pkg::result_type         result;

   // writes are always accepted and take effect in the next cycle
   assign csr_ready = 1'b1;

   always_comb begin
      width_in = width_ff;
      limit_in = limit_ff;
      if (csr_valid) begin
         unique case (met_pkg::csr_index_type'(csr_index))
            met_pkg::CSR_IMAGE_WIDTH:     width_in = csr_data[met_pkg::WIDTH_W-1:0];
            met_pkg::CSR_ITERATION_LIMIT: limit_in = csr_data[met_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= met_pkg::WIDTH_W'(640);
         limit_ff <= met_pkg::LIMIT_W'(5000);
      end else begin
         width_ff <= width_in;
         limit_ff <= limit_in;
      end
   end

   assign cfg.image_width     = width_ff;
   assign cfg.iteration_limit = limit_ff;

   // front end: coordinate scaling and address
   met_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .pixel_x  (req_tdata[11:0]),
      .pixel_y  (req_tdata[23:12]),
      .push     (fe_push),
      .point    (fe_point),
      .full     (q_full)
   );

   // decoupling queue between scaling and iteration
   met_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (fe_push),
      .wdata (fe_point),
      .full  (q_full),
      .pop   (be_pop),
      .rdata (be_point),
      .empty (q_empty)
   );

   // back end: escape-time iteration and result register
   met_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .empty     (q_empty),
      .pop       (be_pop),
      .point     (be_point),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .result    (result)
   );

   assign rsp_tdata = {5'b0, result.byte_address, result.shade, result.in_set,
                       result.iteration_count};

endmodule

// ===== test/escape_time_checker.sv =====
`timescale 1ns / 1ps
module escape_time_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [23:0]                req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [55:0]                rsp_tdata,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [0:0]                 csr_index,
   input  logic [met_pkg::CSR_W-1:0]  csr_data,
   output int                         failures,
   output int                         pending
);

   localparam longint WORD_HI = (longint'(1) << (met_pkg::FRAC_BITS + 3)) - 1;
   localparam longint WORD_LO = -WORD_HI - 1;

   logic [met_pkg::WIDTH_W-1:0] image_width;
   logic [met_pkg::LIMIT_W-1:0] iteration_limit;
   met_pkg::result_type         expected_pixels[$];

   function automatic longint clamp_word(input longint v);
      if (v > WORD_HI) return WORD_HI;
      if (v < WORD_LO) return WORD_LO;
      return v;
   endfunction

   // floor((num << sh) / div), held at the largest positive word
   function automatic longint scaled_quotient(input longint unsigned num, input int sh,
                                              input longint unsigned div);
      longint unsigned q;
      q = (num << sh) / div;
      if (q > WORD_HI) q = WORD_HI;
      return longint'(q);
   endfunction

   function automatic met_pkg::result_type escape_time(
      input logic [met_pkg::PIX_W-1:0] px,
      input logic [met_pkg::PIX_W-1:0] py
   );
      longint unsigned     div, mr, mi, rr, ii, ri, t, addr;
      logic [64:0]         mag_sq;
      longint              c_re, c_im, zr, zi, cross_term;
      int                  count;
      met_pkg::result_type r;
      div  = (image_width == '0) ? 64'(1) : 64'(image_width);
      c_re = scaled_quotient(64'(13 * px), met_pkg::FRAC_BITS - 2, div)
           - (longint'(2) << met_pkg::FRAC_BITS);
      c_im = scaled_quotient(64'(5 * py), met_pkg::FRAC_BITS - 1, div)
           - (longint'(5) << (met_pkg::FRAC_BITS - 2));
      zr = 0;
      zi = 0;
      count = 0;
      while (count < iteration_limit) begin
         mr = (zr < 0) ? -zr : zr;
         mi = (zi < 0) ? -zi : zi;
         rr = mr * mr;
         ii = mi * mi;
         mag_sq = {1'b0, rr} + {1'b0, ii};
         if (mag_sq > (65'd1 << (2 * met_pkg::FRAC_BITS + 2))) break;
         ri = mr * mi;
         t  = ri >> (met_pkg::FRAC_BITS - 1);
         // 2*x*y rounds toward minus infinity, so a negative product rounds away
         if ((zr < 0) != (zi < 0)) begin
            if ((ri & ((64'd1 << (met_pkg::FRAC_BITS - 1)) - 1)) != 0) t++;
            cross_term = -longint'(t);
         end else begin
            cross_term = longint'(t);
         end
         zi = clamp_word(cross_term + c_im);
         zr = clamp_word(longint'(rr >> met_pkg::FRAC_BITS)
                         - longint'(ii >> met_pkg::FRAC_BITS) + c_re);
         count++;
      end
      addr = longint'(3) * image_width * py + longint'(3) * px;
      r.iteration_count = count[met_pkg::COUNT_W-1:0];
      r.in_set          = (count == iteration_limit);
      r.shade           = r.in_set ? '0 : count[met_pkg::SHADE_W-1:0];
      r.byte_address    = addr[met_pkg::ADDR_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input longint unsigned wanted,
                              input longint unsigned got);
      if (wanted != got) begin
         failures++;
         $display("%0t: %s expected %0d got %0d", $time, name, wanted, got);
      end
   endtask

   always @(posedge clock) begin
      met_pkg::result_type actual, wanted;
      if (reset) begin
         image_width     = 13'd640;
         iteration_limit = 16'd5000;
         failures        = 0;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (met_pkg::csr_index_type'(csr_index))
               met_pkg::CSR_IMAGE_WIDTH:
                  image_width = csr_data[met_pkg::WIDTH_W-1:0];
               met_pkg::CSR_ITERATION_LIMIT:
                  iteration_limit = csr_data[met_pkg::LIMIT_W-1:0];
            endcase
         end
         if (req_tvalid && req_tready)
            expected_pixels.push_back(escape_time(req_tdata[11:0], req_tdata[23:12]));
         if (rsp_tvalid && rsp_tready) begin
            actual = met_pkg::result_type'(rsp_tdata[50:0]);
            if (expected_pixels.size() == 0) begin
               failures++;
               $display("%0t: unexpected rsp word expected none got %h", $time, rsp_tdata);
            end else begin
               wanted = expected_pixels.pop_front();
               check_field("iteration_count", 64'(wanted.iteration_count),
                           64'(actual.iteration_count));
               check_field("in_set", 64'(wanted.in_set), 64'(actual.in_set));
               check_field("shade", 64'(wanted.shade), 64'(actual.shade));
               check_field("byte_address", 64'(wanted.byte_address),
                           64'(actual.byte_address));
               check_field("zero fill", 64'd0, 64'(rsp_tdata[55:51]));
            end
         end
      end
      pending = expected_pixels.size();
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

   localparam int CYCLE_LIMIT = 4_000_000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [23:0]                req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [55:0]                rsp_tdata;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [0:0]                 csr_index = met_pkg::CSR_IMAGE_WIDTH;
   logic [met_pkg::CSR_W-1:0]  csr_data = '0;

   int failures;
   int pending;
   int cycles = 0;
   int idle_pct = 0;    // chance per cycle that the pixel source holds off
   int stall_pct = 0;   // chance per cycle that the result sink stalls
   int cur_width = 640; // our own note of image_width, only to shape the pixels

   mandelbrot_escape_time_pixel dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   escape_time_checker pixel_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .failures   (failures),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result sink, stalls at random when asked to
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[mandelbrot_escape_time_pixel] ERROR");
         $finish;
      end
   end

   // one pixel word; valid stays up afterwards so back-to-back words need no gap
   task automatic send_pixel(input logic [met_pkg::PIX_W-1:0] x,
                             input logic [met_pkg::PIX_W-1:0] y);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // drop valid and let every expected word come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input met_pkg::csr_index_type idx,
                            input logic [met_pkg::CSR_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly pixels inside the frame, where the set lives; now and then any coordinate
   task automatic send_random_pixel();
      int x_top, y_top;
      x_top = (cur_width > 4096) ? 4095 : cur_width - 1;
      y_top = (cur_width > 4095) ? 4095 : cur_width;
      if ($urandom_range(0, 7) == 0)
         send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      else
         send_pixel(12'($urandom_range(0, x_top)), 12'($urandom_range(0, y_top)));
   endtask

   initial begin
      int modes_idle[4];
      int modes_stall[4];
      int w;
      modes_idle  = '{0, 74, 0, 38};
      modes_stall = '{0, 0, 74, 38};

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: quick escape, a point deep in the set, far corner,
      // and a column far beyond the width so the real part saturates
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd295, 12'd320);
      send_pixel(12'd639, 12'd479);
      send_pixel(12'd4095, 12'd4095);

      // zero width (upper data bits set, dropped by the register) and zero limit
      write_reg(met_pkg::CSR_IMAGE_WIDTH, 16'hE000);
      write_reg(met_pkg::CSR_ITERATION_LIMIT, 16'h0000);
      cur_width = 1;
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1, 12'd2);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'hAAA, 12'h555);

      // widest register value, smallest non-zero limit
      write_reg(met_pkg::CSR_IMAGE_WIDTH, 16'h1FFF);
      write_reg(met_pkg::CSR_ITERATION_LIMIT, 16'd1);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'h555, 12'hAAA);

      // top limit: two fast escapes and one point that runs the whole way
      write_reg(met_pkg::CSR_IMAGE_WIDTH, 16'd4);
      write_reg(met_pkg::CSR_ITERATION_LIMIT, 16'hFFFF);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4, 12'd4);
      send_pixel(12'd2, 12'd2);

      // random part: four idling modes, two settings in each
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         idle_pct  = modes_idle[p / 2];
         stall_pct = modes_stall[p / 2];
         if (p == 0) w = 4096;
         else if (p == 7) w = 1;
         else w = $urandom_range(2, 1024);
         cur_width = w;
         write_reg(met_pkg::CSR_IMAGE_WIDTH, {3'($urandom_range(0, 7)), 13'(w)});
         write_reg(met_pkg::CSR_ITERATION_LIMIT, 16'($urandom_range(1, 200)));
         repeat (13) send_random_pixel();
      end

      wait_idle();
      repeat (100) @(negedge clock);
      if (failures == 0)
         $display("[mandelbrot_escape_time_pixel] OK");
      else
         $display("[mandelbrot_escape_time_pixel] ERROR");
      $finish;
   end

endmodule
